FILE: rtl/core/led_fx_pkg.sv
// ----------------------------------------------------------------------------
// led_fx_pkg
// Types, codes and the per-channel program step of the LED effect engine.
// ----------------------------------------------------------------------------
`default_nettype none

package led_fx_pkg;

  // Number of duty fields on the result channel
  localparam int unsigned NUM_DUTY       = 6;
  // A tick reports all done when at least this many channels finished
  localparam int unsigned DONE_THRESHOLD = 5;

  // Command codes
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SET  = 1'b1
  } cmd_e;

  // Program codes; the two remaining codes mean idle
  typedef enum logic [2:0] {
    PROG_OFF     = 3'd0,
    PROG_NOMINAL = 3'd1,
    PROG_MAX     = 3'd2,
    PROG_BRAKE   = 3'd3,
    PROG_FADE    = 3'd4,
    PROG_FLASH   = 3'd5
  } prog_e;

  // Phase codes; phase three sends a fade or flash program back to start
  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_RISE  = 2'd1,
    PH_FALL  = 2'd2
  } phase_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_LEVEL_MAX      = 3'd0;
  localparam logic [2:0] CFG_LEVEL_MIN      = 3'd1;
  localparam logic [2:0] CFG_LEVEL_BRAKE    = 3'd2;
  localparam logic [2:0] CFG_LEVEL_FADE_LOW = 3'd3;
  localparam logic [2:0] CFG_NOMINAL_FLASH  = 3'd4;
  localparam logic [2:0] CFG_NOMINAL_BACK   = 3'd5;
  localparam logic [2:0] CFG_NOMINAL_FRONT  = 3'd6;

  typedef struct packed {
    logic [7:0] level_max;
    logic [7:0] level_min;
    logic [7:0] level_brake;
    logic [7:0] level_fade_low;
    logic [7:0] nominal_flash;
    logic [7:0] nominal_back;
    logic [7:0] nominal_front;
  } cfg_t;

  typedef struct packed {
    logic [2:0] prog;
    logic [7:0] level;
    logic [1:0] phase;
    logic [7:0] count;
    logic [7:0] speed;
  } chan_state_t;

  typedef struct packed {
    chan_state_t st;
    logic        done;
  } chan_step_t;

  // Nominal level by channel position: flash pair, back pair, front pair
  function automatic logic [7:0] nominal_of(int unsigned c, cfg_t cfg);
    logic [7:0] r;
    if (c < 2) begin
      r = cfg.nominal_flash;
    end else if (c < 4) begin
      r = cfg.nominal_back;
    end else begin
      r = cfg.nominal_front;
    end
    return r;
  endfunction

  // Run one channel's program for one tick
  function automatic chan_step_t chan_step(chan_state_t s, cfg_t cfg, logic [7:0] nominal);
    chan_step_t r;
    logic [7:0] cnt1;
    logic [7:0] lvl;
    logic [7:0] floor_lvl;
    r         = '{st: s, done: 1'b0};
    cnt1      = s.count + 8'd1;
    lvl       = s.level;
    floor_lvl = (nominal != cfg.level_max) ? cfg.level_fade_low : cfg.level_min;
    case (s.prog)
      PROG_OFF, PROG_NOMINAL, PROG_MAX: begin
        if (s.prog == PROG_OFF) begin
          r.st.level = 8'd0;
        end else if (s.prog == PROG_NOMINAL) begin
          r.st.level = nominal;
        end else begin
          r.st.level = cfg.level_max;
        end
        r.st.speed = 8'd0;
        r.st.phase = PH_START;
        r.st.count = 8'd0;
        r.done     = 1'b1;
      end
      PROG_BRAKE: begin
        r.st.level = cfg.level_brake;
        r.done     = 1'b1;
      end
      PROG_FADE: begin
        case (s.phase)
          PH_START: begin
            r.st.count = 8'd0;
            r.st.phase = PH_RISE;
          end
          PH_RISE: begin
            r.st.count = cnt1;
            if (cnt1 > s.speed) begin
              r.st.count = 8'd0;
              lvl        = s.level + 8'd1;
            end
            // clamp at the ceiling and turn around
            if (lvl > cfg.level_max) begin
              lvl        = cfg.level_max;
              r.st.phase = PH_FALL;
              r.st.count = 8'd0;
            end
            r.st.level = lvl;
            r.done     = 1'b1;
          end
          PH_FALL: begin
            r.st.count = cnt1;
            if (cnt1 > s.speed) begin
              r.st.count = 8'd0;
              lvl        = s.level - 8'd1;
            end
            // clamp at the floor and turn around
            if (lvl <= floor_lvl) begin
              lvl        = floor_lvl;
              r.st.phase = PH_RISE;
              r.st.count = 8'd0;
            end
            r.st.level = lvl;
            r.done     = 1'b1;
          end
          default: begin
            r.st.phase = PH_START;
          end
        endcase
      end
      PROG_FLASH: begin
        case (s.phase)
          PH_START: begin
            r.st.count = 8'd0;
            r.st.phase = PH_RISE;
          end
          PH_RISE: begin
            r.st.count = cnt1;
            if (cnt1 > s.speed) begin
              r.st.count = 8'd0;
              r.st.level = (s.level == cfg.level_max) ? 8'd0 : cfg.level_max;
            end
            r.done = 1'b1;
          end
          default: begin
            r.st.phase = PH_START;
          end
        endcase
      end
      default: begin
        // idle: hold state, report busy
        r.done = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/led_fx_in_if.sv
// ----------------------------------------------------------------------------
// led_fx_in_if
// Command channel of the LED effect engine: tick or channel set beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface led_fx_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [2:0] channel;
  logic       write_all;
  logic [2:0] program_req;
  logic [7:0] level;
  logic [1:0] phase;
  logic [7:0] speed;

  modport source (
    output valid, command, channel, write_all, program_req, level, phase, speed,
    input  ready
  );

  modport sink (
    input  valid, command, channel, write_all, program_req, level, phase, speed,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/led_fx_out_if.sv
// ----------------------------------------------------------------------------
// led_fx_out_if
// Result channel of the LED effect engine: six duties and the all-done flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface led_fx_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] duty_flash_left;
  logic [9:0] duty_flash_right;
  logic [9:0] duty_back_left;
  logic [9:0] duty_back_right;
  logic [9:0] duty_front_left;
  logic [9:0] duty_front_right;
  logic       all_done;

  modport source (
    output valid, duty_flash_left, duty_flash_right, duty_back_left, duty_back_right,
           duty_front_left, duty_front_right, all_done,
    input  ready
  );

  modport sink (
    input  valid, duty_flash_left, duty_flash_right, duty_back_left, duty_back_right,
           duty_front_left, duty_front_right, all_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/six_channel_led_effect_engine_core.sv
// ----------------------------------------------------------------------------
// six_channel_led_effect_engine_core
// Six LED channels running fixed, flash and slow fade programs per tick.
// ----------------------------------------------------------------------------
// Each beat on in_chan is either a set command, which writes one channel's
// program (and with write_all its level, phase and speed) and gives no
// result, or a tick, which runs every channel's program once and gives one
// beat on out_chan in the next cycle with the six duties (level times four)
// and the all-done flag. One beat is taken every cycle: the channel update
// is a single pass of small adds and compares from the state registers into
// the result register. A waiting result stalls further ticks only; set beats
// are still taken. Configuration writes are expected while no result waits.
`default_nettype none

module six_channel_led_effect_engine_core #(
  parameter int unsigned CHANNELS = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  led_fx_in_if.sink       in_chan,
  led_fx_out_if.source    out_chan,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  localparam int unsigned DoneW = $clog2(CHANNELS + 1);

  led_fx_pkg::cfg_t        cfg_r;
  led_fx_pkg::chan_state_t chan_r   [CHANNELS];
  led_fx_pkg::chan_state_t chan_nxt [CHANNELS];
  logic [9:0]              duty_nxt [led_fx_pkg::NUM_DUTY];
  logic [9:0]              duty_r   [led_fx_pkg::NUM_DUTY];
  logic                    all_done_nxt;
  logic                    all_done_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic                    in_accept;
  logic                    is_tick;
  logic [DoneW-1:0]        done_cnt;

  // Take sets always; take ticks when the result register is free or being taken
  assign is_tick       = (in_chan.command == led_fx_pkg::CMD_TICK);
  assign in_chan.ready = !is_tick || !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{level_max: 8'd250, level_min: 8'd0, level_brake: 8'd200,
                 level_fade_low: 8'd20, nominal_flash: 8'd250,
                 nominal_back: 8'd60, nominal_front: 8'd100};
    end else if (cfg_we) begin
      unique case (cfg_index)
        led_fx_pkg::CFG_LEVEL_MAX:      cfg_r.level_max      <= cfg_wdata;
        led_fx_pkg::CFG_LEVEL_MIN:      cfg_r.level_min      <= cfg_wdata;
        led_fx_pkg::CFG_LEVEL_BRAKE:    cfg_r.level_brake    <= cfg_wdata;
        led_fx_pkg::CFG_LEVEL_FADE_LOW: cfg_r.level_fade_low <= cfg_wdata;
        led_fx_pkg::CFG_NOMINAL_FLASH:  cfg_r.nominal_flash  <= cfg_wdata;
        led_fx_pkg::CFG_NOMINAL_BACK:   cfg_r.nominal_back   <= cfg_wdata;
        led_fx_pkg::CFG_NOMINAL_FRONT:  cfg_r.nominal_front  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Compute next channel state, duties and the finished count
  always_comb begin
    led_fx_pkg::chan_step_t step;
    done_cnt = '0;
    for (int unsigned d = 0; d < led_fx_pkg::NUM_DUTY; d++) begin
      duty_nxt[d] = 10'd0;
    end
    for (int unsigned c = 0; c < CHANNELS; c++) begin
      step        = led_fx_pkg::chan_step(chan_r[c], cfg_r, led_fx_pkg::nominal_of(c, cfg_r));
      chan_nxt[c] = chan_r[c];
      if (in_accept) begin
        if (is_tick) begin
          chan_nxt[c] = step.st;
        end else if (in_chan.channel == 3'(c)) begin
          chan_nxt[c].prog = in_chan.program_req;
          if (in_chan.write_all) begin
            chan_nxt[c].level = in_chan.level;
            chan_nxt[c].phase = in_chan.phase;
            chan_nxt[c].speed = in_chan.speed;
          end
        end
      end
      duty_nxt[c] = {step.st.level, 2'b00};
      done_cnt    = done_cnt + DoneW'(step.done);
    end
    all_done_nxt = (32'(done_cnt) >= led_fx_pkg::DONE_THRESHOLD);
  end

  // Hold the result until taken; load it on a tick
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_accept && is_tick) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Channel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned c = 0; c < CHANNELS; c++) begin
        chan_r[c] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int unsigned c = 0; c < CHANNELS; c++) begin
        chan_r[c] <= chan_nxt[c];
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (in_accept && is_tick) begin
      duty_r     <= duty_nxt;
      all_done_r <= all_done_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.duty_flash_left  = duty_r[0];
  assign out_chan.duty_flash_right = duty_r[1];
  assign out_chan.duty_back_left   = duty_r[2];
  assign out_chan.duty_back_right  = duty_r[3];
  assign out_chan.duty_front_left  = duty_r[4];
  assign out_chan.duty_front_right = duty_r[5];
  assign out_chan.all_done         = all_done_r;

  // A tick beat always yields a result in the next cycle
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_tick) |=> out_chan.valid)
    else $error("tick beat produced no result");

  // A set beat never creates a result
  a_set_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !is_tick) |=> (out_chan.valid == $past(out_chan.valid && !out_chan.ready)))
    else $error("set beat changed result valid");

  // Input stalls only for a tick behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (is_tick && out_chan.valid && !out_chan.ready))
    else $error("input stalled without a waiting result");

  // Off program on channel 0 clears its level and count on a tick
  a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_tick && chan_r[0].prog == led_fx_pkg::PROG_OFF)
      |=> (chan_r[0].level == 8'd0 && chan_r[0].count == 8'd0))
    else $error("off program left channel level or count set");

endmodule

`default_nettype wire
